// File: src/sfr_pkg.sv
// Shared types and constants for the symbol frequency ranker.
// No dependencies.
package sfr_pkg;

	localparam logic [1:0] OP_COUNT = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD1,
		ST_SCAN,
		ST_LOAD2,
		ST_PICK,
		ST_DONE
	} state_t;

	// control broadcast to every cell
	typedef struct packed {
		logic cnt_en;   // count the broadcast symbol
		logic clr;      // clear all counts
		logic ld_scan;  // load ring with own entry, zero position
		logic ld_pick;  // load ring with own entry and position
		logic scan;     // compare passing entry, then shift
		logic pick;     // shift only
		logic mode;     // 1 ranks by descending count
	} cell_ctrl_t;

endpackage

// File: src/sfr_cell.sv
// One bin of the ranker: count, rank position and one ring stage.
// Depends on sfr_pkg.
module sfr_cell import sfr_pkg::*; #(
	parameter int NUM_BINS    = 128,
	parameter int COUNT_WIDTH = 32,
	parameter int IDX         = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cell_ctrl_t                  ctrl,
	input  logic [$clog2(NUM_BINS)-1:0] sym,
	input  logic [COUNT_WIDTH-1:0]      t_cnt_in,
	input  logic [$clog2(NUM_BINS)-1:0] t_code_in,
	input  logic [$clog2(NUM_BINS)-1:0] t_pos_in,
	output logic [COUNT_WIDTH-1:0]      t_cnt_out,
	output logic [$clog2(NUM_BINS)-1:0] t_code_out,
	output logic [$clog2(NUM_BINS)-1:0] t_pos_out
);

	localparam int CW = $clog2(NUM_BINS);
	localparam logic [CW-1:0] MY_CODE = CW'(IDX);

	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [CW-1:0]          pos_q;
	logic [COUNT_WIDTH-1:0] t_cnt_q;
	logic [CW-1:0]          t_code_q;
	logic [CW-1:0]          t_pos_q;
	logic                   ahead;

	// passing entry ranks ahead of this bin
	always_comb begin
		if (ctrl.mode)
			ahead = (t_cnt_q > cnt_q) || ((t_cnt_q == cnt_q) && (t_code_q < MY_CODE));
		else
			ahead = t_code_q < MY_CODE;
		ahead = ahead && (t_cnt_q != '0);
	end

	// saturating bin count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.clr) begin
			cnt_q <= '0;
		end else if (ctrl.cnt_en && (sym == MY_CODE) && (cnt_q != '1)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// position among nonzero bins
	always_ff @(posedge clk) begin
		if (ctrl.ld_scan)
			pos_q <= '0;
		else if (ctrl.scan && ahead)
			pos_q <= pos_q + 1'b1;
	end

	// ring stage
	always_ff @(posedge clk) begin
		if (ctrl.ld_scan || ctrl.ld_pick) begin
			t_cnt_q  <= cnt_q;
			t_code_q <= MY_CODE;
			t_pos_q  <= ctrl.ld_pick ? pos_q : '0;
		end else if (ctrl.scan || ctrl.pick) begin
			t_cnt_q  <= t_cnt_in;
			t_code_q <= t_code_in;
			t_pos_q  <= t_pos_in;
		end
	end

	assign t_cnt_out  = t_cnt_q;
	assign t_code_out = t_code_q;
	assign t_pos_out  = t_pos_q;

endmodule

// File: src/symbol_frequency_ranker.sv
// Top level of the symbol frequency ranker: control, totals and ring of cells.
// Depends on sfr_pkg and sfr_cell.
//
//  channel | direction | handshake          | word
//  in      | to block  | in_valid/in_stall  | opcode, data_byte, rank
//  out     | from block| out_valid/out_stall| symbol_code .. total_bytes
//  cfg     | to block  | cfg_we             | cfg_wdata (order_mode)
//
// Count and clear words may follow back to back.
// A read holds in_stall through two full turns of the ring of cells
// (ranking, then selection), each after a load state, and a finish state.
// The result sits in an output register; the block takes new words while it
// waits, and a later read finishes only once that register is free.
// Reset clears all counts, the total and order_mode to descending count.
module symbol_frequency_ranker import sfr_pkg::*; #(
	parameter int NUM_BINS    = 128,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [6:0]  rank,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  symbol_code,
	output logic [31:0] symbol_count,
	output logic        entry_valid,
	output logic [7:0]  distinct_symbols,
	output logic [31:0] total_bytes,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	localparam int CW = $clog2(NUM_BINS);
	localparam int DW = $clog2(NUM_BINS + 1);
	localparam logic [CW-1:0] LAST_STEP = CW'(NUM_BINS - 1);

	state_t                 state_q, state_d;
	cell_ctrl_t             ctrl;
	logic                   order_mode_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [6:0]             rank_q;
	logic [CW-1:0]          step_q;
	logic [DW-1:0]          distinct_q;
	logic                   hit_q;
	logic [CW-1:0]          hit_code_q;
	logic [COUNT_WIDTH-1:0] hit_cnt_q;
	logic                   accept;
	logic                   printable;
	logic                   last_step;
	logic                   out_free;
	logic [CW-1:0]          sym;
	logic [63:0]            hit_cnt_w;
	logic [63:0]            total_w;

	logic [COUNT_WIDTH-1:0] t_cnt  [NUM_BINS];
	logic [CW-1:0]          t_code [NUM_BINS];
	logic [CW-1:0]          t_pos  [NUM_BINS];

	assign accept    = in_valid && !in_stall;
	assign printable = (data_byte >= PRINT_LO) && (data_byte <= PRINT_HI);
	assign sym       = CW'(data_byte);
	assign last_step = step_q == LAST_STEP;
	assign out_free  = !out_valid || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && opcode == OP_READ) state_d = ST_LOAD1;
			ST_LOAD1: state_d = ST_SCAN;
			ST_SCAN:  if (last_step) state_d = ST_LOAD2;
			ST_LOAD2: state_d = ST_PICK;
			ST_PICK:  if (last_step) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// cell control and stall
	always_comb begin
		ctrl         = '0;
		ctrl.mode    = order_mode_q;
		ctrl.cnt_en  = accept && (opcode == OP_COUNT) && printable;
		ctrl.clr     = accept && (opcode == OP_CLEAR);
		ctrl.ld_scan = state_q == ST_LOAD1;
		ctrl.scan    = state_q == ST_SCAN;
		ctrl.ld_pick = state_q == ST_LOAD2;
		ctrl.pick    = state_q == ST_PICK;
		in_stall     = state_q != ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			order_mode_q <= 1'b1;
		else if (cfg_we)
			order_mode_q <= cfg_wdata;
	end

	// saturating byte total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (accept && opcode == OP_CLEAR) begin
			total_q <= '0;
		end else if (accept && opcode == OP_COUNT && total_q != '1) begin
			total_q <= total_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			rank_q <= rank;
	end

	// step counter for both ring turns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if ((ctrl.scan || ctrl.pick) && !last_step)
			step_q <= step_q + 1'b1;
		else
			step_q <= '0;
	end

	// distinct count and selection at the ring tap
	always_ff @(posedge clk) begin
		if (ctrl.ld_scan)
			distinct_q <= '0;
		else if (ctrl.scan && t_cnt[NUM_BINS-1] != '0)
			distinct_q <= distinct_q + 1'b1;

		if (ctrl.ld_pick) begin
			hit_q      <= 1'b0;
			hit_code_q <= '0;
			hit_cnt_q  <= '0;
		end else if (ctrl.pick && t_cnt[NUM_BINS-1] != '0
				&& t_pos[NUM_BINS-1] == CW'(rank_q)) begin
			hit_q      <= 1'b1;
			hit_code_q <= t_code[NUM_BINS-1];
			hit_cnt_q  <= t_cnt[NUM_BINS-1];
		end
	end

	// ring of cells
	for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
		localparam int PREV = (i == 0) ? NUM_BINS - 1 : i - 1;
		sfr_cell #(
			.NUM_BINS(NUM_BINS),
			.COUNT_WIDTH(COUNT_WIDTH),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.sym(sym),
			.t_cnt_in(t_cnt[PREV]),
			.t_code_in(t_code[PREV]),
			.t_pos_in(t_pos[PREV]),
			.t_cnt_out(t_cnt[i]),
			.t_code_out(t_code[i]),
			.t_pos_out(t_pos[i])
		);
	end

	assign hit_cnt_w = 64'(hit_cnt_q);
	assign total_w   = 64'(total_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			symbol_code      <= 7'(hit_code_q);
			symbol_count     <= hit_cnt_w[31:0];
			entry_valid      <= hit_q;
			distinct_symbols <= 8'(distinct_q);
			total_bytes      <= total_w[31:0];
		end
	end

endmodule

// File: src/sfr_checker.sv
// Port-level checks for the symbol frequency ranker, bound to the top level.
// Depends on sfr_pkg and symbol_frequency_ranker.
module sfr_props import sfr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  opcode,
	input logic        out_valid,
	input logic        out_stall,
	input logic [6:0]  symbol_code,
	input logic [31:0] symbol_count,
	input logic        entry_valid,
	input logic [7:0]  distinct_symbols,
	input logic [31:0] total_bytes
);

	// an accepted read keeps the input side stalled while it ranks
	a_read_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == OP_READ |=> in_stall)
		else $error("read did not stall input");

	// a new result only appears at the end of a read
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a read in progress");

	// a missing entry reports zero code and count
	a_empty_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> symbol_code == 7'd0 && symbol_count == 32'd0)
		else $error("missing entry with nonzero fields");

	// a present entry implies at least one distinct symbol
	a_entry_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_valid |-> distinct_symbols != 8'd0)
		else $error("entry present with no distinct symbols");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(symbol_code)
			&& $stable(symbol_count) && $stable(total_bytes))
		else $error("stalled result changed");

endmodule

bind symbol_frequency_ranker sfr_props u_sfr_props (.*);

// File: dv/sfr_checker.sv
// Checker for the symbol frequency ranker: watches the input, config and output channels,
// keeps its own histogram and ranking, and compares every read result.
// Depends on sfr_pkg.
`timescale 1ns / 100ps
module sfr_checker import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [6:0]  rank,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [6:0]  symbol_code,
	input  logic [31:0] symbol_count,
	input  logic        entry_valid,
	input  logic [7:0]  distinct_symbols,
	input  logic [31:0] total_bytes,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [6:0]  code;
		logic [31:0] count;
		logic        valid;
		logic [7:0]  distinct;
		logic [31:0] total;
	} rank_entry_t;

	logic [31:0] hist [128];
	logic [31:0] byte_sum;
	logic        desc_mode;
	rank_entry_t expected_entries [$];

	// builds the ordering on the fly and looks up the requested rank
	function automatic rank_entry_t lookup_rank(input logic [6:0] r);
		rank_entry_t e;
		int order [$];
		int j;
		int tmp;
		e = '0;
		for (int i = 0; i < 128; i++)
			if (hist[i] != 0) order.push_back(i);
		if (desc_mode) begin
			// stable insertion sort, descending count
			for (int i = 1; i < order.size(); i++) begin
				tmp = order[i];
				j = i;
				while (j > 0 && hist[order[j-1]] < hist[tmp]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = tmp;
			end
		end
		if (r < order.size()) begin
			e.code = 7'(order[r]);
			e.count = hist[order[r]];
			e.valid = 1'b1;
		end
		e.distinct = 8'(order.size());
		e.total = byte_sum;
		return e;
	endfunction

	assign pending = expected_entries.size();

	always @(posedge clk or negedge arst_n) begin
		rank_entry_t got;
		rank_entry_t want;
		if (!arst_n) begin
			for (int i = 0; i < 128; i++) hist[i] <= '0;
			byte_sum <= '0;
			desc_mode <= 1'b1;
			fail_count <= 0;
			expected_entries.delete();
		end else begin
			if (cfg_we) desc_mode <= cfg_wdata;
			// predict on accepted input word
			if (in_valid && !in_stall) begin
				case (opcode)
					OP_COUNT: begin
						if (byte_sum != '1) byte_sum <= byte_sum + 32'd1;
						if (data_byte >= PRINT_LO && data_byte <= PRINT_HI &&
						    hist[data_byte[6:0]] != '1)
							hist[data_byte[6:0]] <= hist[data_byte[6:0]] + 32'd1;
					end
					OP_CLEAR: begin
						for (int i = 0; i < 128; i++) hist[i] <= '0;
						byte_sum <= '0;
					end
					OP_READ: expected_entries.push_back(lookup_rank(rank));
					default: ;
				endcase
			end
			// compare accepted result word
			if (out_valid && !out_stall) begin
				got = '{symbol_code, symbol_count, entry_valid, distinct_symbols, total_bytes};
				if (expected_entries.size() == 0) begin
					$error("unexpected result word");
					fail_count <= fail_count + 1;
				end else begin
					want = expected_entries.pop_front();
					if (got != want) begin
						fail_count <= fail_count + 1;
						if (got.code != want.code)
							$error("symbol_code exp %0d got %0d", want.code, got.code);
						if (got.count != want.count)
							$error("symbol_count exp %0d got %0d", want.count, got.count);
						if (got.valid != want.valid)
							$error("entry_valid exp %0d got %0d", want.valid, got.valid);
						if (got.distinct != want.distinct)
							$error("distinct_symbols exp %0d got %0d",
								want.distinct, got.distinct);
						if (got.total != want.total)
							$error("total_bytes exp %0d got %0d", want.total, got.total);
					end
				end
			end
		end
	end

endmodule

// File: dv/tb_top.sv
// Testbench top for the symbol frequency ranker: stimulus, config phases and verdict.
// Depends on sfr_pkg, symbol_frequency_ranker and sfr_checker.
`timescale 1ns / 100ps
module tb_top;
	import sfr_pkg::*;

	localparam int MAX_CYCLES = 2000000;
	localparam int DRAIN_CYCLES = 600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = OP_COUNT;
	logic [7:0]  data_byte = '0;
	logic [6:0]  rank = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  symbol_code;
	logic [31:0] symbol_count;
	logic        entry_valid;
	logic [7:0]  distinct_symbols;
	logic [31:0] total_bytes;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	int          burst_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	symbol_frequency_ranker uut (.*);
	sfr_checker checker_i (.*);

	// receiver stall pattern: phases of no stall, light and heavy stall
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		case ((cycle_count / 3000) % 3)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (cycle_count >= MAX_CYCLES) begin
			$display("symbol_frequency_ranker test failed");
			$finish;
		end
	end

	// send one word, burst/gap idling on the sender side
	task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic [6:0] r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1'b1;
		opcode <= op;
		data_byte <= b;
		rank <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_order(input logic m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random word: mostly bytes from a small skewed alphabet, reads, rare clears and reserved opcodes
	task automatic random_word();
		int sel;
		logic [7:0] b;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
			else b = 8'(32'h20 + $urandom_range(0, $urandom_range(0, 94)));
			send_word(OP_COUNT, b, 7'($urandom));
		end else if (sel < 92) begin
			send_word(OP_READ, 8'($urandom),
				($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12)));
		end else if (sel < 96) begin
			send_word(OP_CLEAR, 8'($urandom), 7'($urandom));
		end else begin
			send_word(OP_RSVD, 8'($urandom), 7'($urandom));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: read empty, edge bytes, ties, out-of-range rank
		send_word(OP_READ, 8'h00, 7'd0);
		send_word(OP_COUNT, 8'h1F, 7'd0);
		send_word(OP_COUNT, 8'h20, 7'd0);
		send_word(OP_COUNT, 8'h7E, 7'd0);
		send_word(OP_COUNT, 8'h7F, 7'd0);
		send_word(OP_COUNT, 8'hFF, 7'd0);
		send_word(OP_COUNT, 8'h00, 7'd0);
		send_word(OP_COUNT, 8'h7E, 7'd0);
		send_word(OP_COUNT, 8'h41, 7'd0);
		send_word(OP_READ, 8'h00, 7'd0);
		send_word(OP_READ, 8'h00, 7'd1);
		send_word(OP_READ, 8'h00, 7'd2);
		send_word(OP_READ, 8'h00, 7'd3);
		send_word(OP_READ, 8'h00, 7'd127);
		send_word(OP_RSVD, 8'hFF, 7'd127);
		send_word(OP_READ, 8'hFF, 7'd1);
		settle_idle();
		write_order(1'b0);
		send_word(OP_READ, 8'h00, 7'd0);
		send_word(OP_READ, 8'h00, 7'd2);
		send_word(OP_CLEAR, 8'h00, 7'd0);
		send_word(OP_READ, 8'h00, 7'd0);
		settle_idle();
		write_order(1'b1);

		// random phases, switching order mode between them
		for (int ph = 0; ph < 6; ph++) begin
			for (int i = 0; i < 155; i++) random_word();
			settle_idle();
			write_order(ph[0]);
		end
		// fill all printable bins so rank reaches the top of the range
		for (int c = 8'h20; c <= 8'h7E; c++) send_word(OP_COUNT, 8'(c), 7'd0);
		send_word(OP_READ, 8'h00, 7'd94);
		send_word(OP_READ, 8'h00, 7'd95);
		settle_idle();
		write_order(1'b1);

		if (fail_count == 0) begin
			$display("symbol_frequency_ranker test passed");
		end else begin
			$display("symbol_frequency_ranker test failed");
		end
		$finish;
	end

endmodule
